[src/pidtm_pkg.sv]
`timescale 1ns / 1ps

package pidtm_pkg;

	// Defaults for the top-level parameters.
	localparam int unsigned FRAC_BITS_DEF = 8;
	localparam int unsigned ACC_WIDTH_DEF = 40;

	// Fixed field widths.
	localparam int unsigned DATA_W  = 24;
	localparam int unsigned ERR_W   = 25;
	localparam int unsigned GAIN_W  = 16;
	localparam int unsigned LIMIT_W = 23;
	localparam int unsigned DRIVE_W = 16;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 23;

	// Shared multiplier: signed A times a zero-extended 16-bit factor.
	localparam int unsigned MUL_A_W = 26;
	localparam int unsigned MUL_B_W = 17;
	localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

	// Accumulator view fed to the integral product, limited to +-2^40.
	localparam int unsigned MS_W      = 42;
	localparam int unsigned MS_LO_W   = 21;
	localparam int unsigned ILO_W     = 29;
	localparam int unsigned ITERM_W   = 51;
	localparam int unsigned TOTAL_W   = 36;
	localparam logic [63:0] MS_LIMIT  = 64'd1 << 40;

	// Error scale of 0.7 in speed mode, as a 16-bit fraction.
	localparam logic [MUL_B_W-1:0] SCALE_07 = 17'd45875;

	// Bands in whole units, shifted by the fraction width in the datapath.
	localparam int unsigned ZERO_BAND_INT  = 100;
	localparam int unsigned INTEG_BAND_INT = 400;
	localparam int unsigned LARGE_ERR_INT  = 30;

	localparam logic [23:0] DRIVE_POS_CAP = 24'd32767;
	localparam logic [23:0] DRIVE_NEG_CAP = 24'd32768;
	localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 16'sh7fff;
	localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = 16'sh8000;

	// Operating modes.
	localparam logic [1:0] MODE_OFF   = 2'd0;
	localparam logic [1:0] MODE_SPEED = 2'd1;
	localparam logic [1:0] MODE_ANGLE = 2'd2;
	localparam logic [1:0] MODE_PLAIN = 2'd3;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_MODE         = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DERIV_ENABLE = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_ALT_SELECT   = 3'd7;

	function automatic logic [ERR_W-1:0] err_mag(input logic signed [ERR_W-1:0] v);
		return v[ERR_W-1] ? ERR_W'(-v) : ERR_W'(v);
	endfunction

endpackage

[src/pid_controller_two_mode_unit.sv]
`timescale 1ns / 1ps

// Channel   Handshake                  Payload
// sample    sample_valid/sample_stall  setpoint, measured
// result    result_valid/result_stall  drive, integrating
// config    cfg_valid/cfg_ready        cfg_index, cfg_data
//
// A request in the off mode goes from acceptance straight to the output state;
// with shaping, integral and derivative terms all active it steps through the
// states in turn, the single 26 x 17 multiplier serving the scale, gain and
// derivative products. A new sample is taken only while the sequencer is idle.
// The result register holds a finished request while result_stall is high.
// Reset clears the configuration, the integrator and the previous error.
module pid_controller_two_mode_unit import pidtm_pkg::*; #(
	parameter int unsigned FRAC_BITS = FRAC_BITS_DEF,
	parameter int unsigned ACC_WIDTH = ACC_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         sample_valid,
	output logic                         sample_stall,
	input  logic signed [DATA_W-1:0]     setpoint,
	input  logic signed [DATA_W-1:0]     measured,
	output logic                         result_valid,
	input  logic                         result_stall,
	output logic signed [DRIVE_W-1:0]    drive,
	output logic                         integrating,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data
);

	localparam int unsigned AW1 = ACC_WIDTH + 1;
	localparam int unsigned XW  = (ACC_WIDTH > MS_W) ? ACC_WIDTH : MS_W;

	localparam logic [31:0] BAND_ZERO  = 32'(ZERO_BAND_INT) << FRAC_BITS;
	localparam logic [31:0] BAND_INTEG = 32'(INTEG_BAND_INT) << FRAC_BITS;
	localparam logic [31:0] BAND_LARGE = 32'(LARGE_ERR_INT) << FRAC_BITS;
	localparam logic [31:0] BAND_HALF  = 32'd1 << (FRAC_BITS - 1);

	localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
	localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};
	localparam logic signed [XW-1:0] BIG_X     = XW'(MS_LIMIT);
	localparam logic signed [XW-1:0] NEG_BIG_X = -BIG_X;

	typedef enum logic [12:0] {
		S_IDLE  = 13'b0000000000001,
		S_SCALE = 13'b0000000000010,
		S_SHAPE = 13'b0000000000100,
		S_PROP  = 13'b0000000001000,
		S_PACC  = 13'b0000000010000,
		S_ILO   = 13'b0000000100000,
		S_IHI   = 13'b0000001000000,
		S_ISUM  = 13'b0000010000000,
		S_IADD  = 13'b0000100000000,
		S_DMUL  = 13'b0001000000000,
		S_DADD  = 13'b0010000000000,
		S_CLAMP = 13'b0100000000000,
		S_OUT   = 13'b1000000000000
	} seq_state_t;

	seq_state_t state_q;

	// Configuration.
	logic [1:0]          mode_q;
	logic [GAIN_W-1:0]   prop_gain_q, integ_gain_q, deriv_gain_q;
	logic [LIMIT_W-1:0]  integ_limit_q, drive_limit_q;
	logic                deriv_enable_q, alt_select_q;

	// Loop state.
	logic signed [ACC_WIDTH-1:0] integ_sum_q;
	logic signed [ERR_W-1:0]     prev_error_q;
	logic                        integ_active_q;

	// Working registers of one request.
	logic signed [ERR_W-1:0]   e_q;
	logic                      spz_q;
	logic                      off_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [MS_W-1:0]    ms_q;
	logic [ILO_W-1:0]          iacc_q;
	logic signed [ITERM_W-1:0] iterm_q;
	logic signed [TOTAL_W-1:0] total_q;

	logic                      result_valid_q;
	logic signed [DRIVE_W-1:0] drive_q;
	logic                      integrating_q;

	logic sample_take;
	logic out_load;
	logic cfg_take;

	// Shared multiplier.
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  prod_n;

	// Shaping.
	logic signed [ERR_W-1:0] es;
	logic [31:0]             es_mag;
	logic signed [ERR_W-1:0] e_n;
	logic                    act_n;
	logic                    clr_n;

	// Integrator and terms.
	logic signed [AW1-1:0]       sum_w;
	logic signed [ACC_WIDTH-1:0] sum_sat;
	logic signed [XW-1:0]        sum_x;
	logic signed [MS_W-1:0]      ms_n;
	logic signed [ITERM_W-1:0]   ilim;
	logic signed [ITERM_W-1:0]   iclamp;
	logic signed [TOTAL_W-1:0]   prod_term;
	logic signed [TOTAL_W-1:0]   dlim;
	logic signed [TOTAL_W-1:0]   total_clamp;
	logic [23:0]                 tmag;
	logic [23:0]                 tsh;
	logic signed [DRIVE_W-1:0]   drive_n;

	assign sample_stall = (state_q != S_IDLE);
	assign sample_take  = sample_valid && !sample_stall;
	assign out_load     = (state_q == S_OUT) && !(result_valid_q && result_stall);
	assign cfg_ready    = 1'b1;
	assign cfg_take     = cfg_valid && cfg_ready;

	assign result_valid = result_valid_q;
	assign drive        = drive_q;
	assign integrating  = integrating_q;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_SCALE: begin
				mul_a = MUL_A_W'(e_q);
				mul_b = SCALE_07;
			end
			S_PROP: begin
				mul_a = MUL_A_W'(e_q);
				mul_b = {1'b0, prop_gain_q};
			end
			S_ILO: begin
				mul_a = MUL_A_W'({1'b0, ms_q[MS_LO_W-1:0]});
				mul_b = {1'b0, integ_gain_q};
			end
			S_IHI: begin
				mul_a = MUL_A_W'($signed(ms_q[MS_W-1:MS_LO_W]));
				mul_b = {1'b0, integ_gain_q};
			end
			S_DMUL: begin
				mul_a = MUL_A_W'(e_q) - MUL_A_W'(prev_error_q);
				mul_b = {1'b0, deriv_gain_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod_n = mul_a * mul_b;

	// The scaled error sits in the product register when speed mode shapes it.
	always_comb begin
		es     = (mode_q == MODE_SPEED) ? prod_q[40:16] : e_q;
		es_mag = 32'(err_mag(es));
		e_n    = es;
		act_n  = integ_active_q;
		clr_n  = 1'b0;
		case (mode_q)
			MODE_SPEED: begin
				if (spz_q && es_mag < BAND_ZERO) begin
					e_n = '0;
				end
				act_n = !spz_q && es_mag < BAND_INTEG;
				clr_n = !act_n;
			end
			MODE_ANGLE: begin
				if (!alt_select_q && es_mag < BAND_HALF) begin
					e_n = '0;
				end
				act_n = alt_select_q && es_mag > BAND_LARGE;
				clr_n = !act_n;
			end
			default: begin
				e_n   = es;
				act_n = integ_active_q;
				clr_n = 1'b0;
			end
		endcase
	end

	// Saturating accumulate: an overflow shows as the top two bits differing.
	assign sum_w = AW1'(integ_sum_q) + AW1'(e_q);
	always_comb begin
		if (sum_w[AW1-1] != sum_w[AW1-2]) begin
			sum_sat = sum_w[AW1-1] ? ACC_MIN : ACC_MAX;
		end else begin
			sum_sat = sum_w[ACC_WIDTH-1:0];
		end
	end

	assign sum_x = XW'(integ_sum_q);
	always_comb begin
		if (sum_x > BIG_X) begin
			ms_n = BIG_X[MS_W-1:0];
		end else if (sum_x < NEG_BIG_X) begin
			ms_n = NEG_BIG_X[MS_W-1:0];
		end else begin
			ms_n = sum_x[MS_W-1:0];
		end
	end

	assign ilim = $signed(ITERM_W'(integ_limit_q));
	always_comb begin
		if (iterm_q > ilim) begin
			iclamp = ilim;
		end else if (iterm_q < -ilim) begin
			iclamp = -ilim;
		end else begin
			iclamp = iterm_q;
		end
	end

	// The proportional and derivative products drop eight fraction bits with an arithmetic shift.
	assign prod_term = TOTAL_W'($signed(prod_q[PROD_W-1:8]));

	assign dlim = $signed(TOTAL_W'(drive_limit_q));
	always_comb begin
		if (total_q > dlim) begin
			total_clamp = dlim;
		end else if (total_q < -dlim) begin
			total_clamp = -dlim;
		end else begin
			total_clamp = total_q;
		end
	end

	// Truncation toward zero works on the magnitude, then restores the sign.
	assign tmag = total_q[TOTAL_W-1] ? 24'(-total_q) : 24'(total_q);
	assign tsh  = tmag >> FRAC_BITS;
	always_comb begin
		if (off_q) begin
			drive_n = '0;
		end else if (!total_q[TOTAL_W-1]) begin
			drive_n = (tsh > DRIVE_POS_CAP) ? DRIVE_MAX : $signed(tsh[DRIVE_W-1:0]);
		end else begin
			drive_n = (tsh >= DRIVE_NEG_CAP) ? DRIVE_MIN : $signed(16'(-tsh));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			result_valid_q <= 1'b0;
			mode_q         <= MODE_OFF;
			prop_gain_q    <= '0;
			integ_gain_q   <= '0;
			deriv_gain_q   <= '0;
			integ_limit_q  <= '0;
			drive_limit_q  <= '0;
			deriv_enable_q <= 1'b0;
			alt_select_q   <= 1'b0;
			integ_sum_q    <= '0;
			prev_error_q   <= '0;
			integ_active_q <= 1'b0;
		end else begin
			if (cfg_take) begin
				case (cfg_index)
					REG_MODE:         mode_q         <= cfg_data[1:0];
					REG_PROP_GAIN:    prop_gain_q    <= cfg_data[GAIN_W-1:0];
					REG_INTEG_GAIN:   integ_gain_q   <= cfg_data[GAIN_W-1:0];
					REG_DERIV_GAIN:   deriv_gain_q   <= cfg_data[GAIN_W-1:0];
					REG_INTEG_LIMIT:  integ_limit_q  <= cfg_data[LIMIT_W-1:0];
					REG_DRIVE_LIMIT:  drive_limit_q  <= cfg_data[LIMIT_W-1:0];
					REG_DERIV_ENABLE: deriv_enable_q <= cfg_data[0];
					REG_ALT_SELECT:   alt_select_q   <= cfg_data[0];
					default: ;
				endcase
			end

			if (out_load) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (sample_take) begin
						if (mode_q == MODE_OFF) begin
							state_q <= S_OUT;
						end else if (mode_q == MODE_SPEED) begin
							state_q <= S_SCALE;
						end else begin
							state_q <= S_SHAPE;
						end
					end
				end
				S_SCALE: state_q <= S_SHAPE;
				S_SHAPE: begin
					integ_active_q <= act_n;
					if (clr_n) begin
						integ_sum_q <= '0;
					end
					state_q <= S_PROP;
				end
				S_PROP: begin
					if (integ_active_q) begin
						integ_sum_q <= sum_sat;
					end
					state_q <= S_PACC;
				end
				S_PACC: begin
					if (integ_active_q) begin
						state_q <= S_ILO;
					end else if (deriv_enable_q) begin
						state_q <= S_DMUL;
					end else begin
						state_q <= S_CLAMP;
					end
				end
				S_ILO:  state_q <= S_IHI;
				S_IHI:  state_q <= S_ISUM;
				S_ISUM: state_q <= S_IADD;
				S_IADD: state_q <= deriv_enable_q ? S_DMUL : S_CLAMP;
				S_DMUL: begin
					prev_error_q <= e_q;
					state_q      <= S_DADD;
				end
				S_DADD:  state_q <= S_CLAMP;
				S_CLAMP: state_q <= S_OUT;
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= prod_n;
		if (sample_take) begin
			e_q   <= ERR_W'(setpoint) - ERR_W'(measured);
			spz_q <= (setpoint == '0);
			off_q <= (mode_q == MODE_OFF);
		end
		case (state_q)
			S_SHAPE: e_q <= e_n;
			S_PACC: begin
				total_q <= prod_term;
				ms_q    <= ms_n;
			end
			S_IHI:  iacc_q  <= prod_q[ILO_W+7:8];
			S_ISUM: iterm_q <= (ITERM_W'($signed(prod_q[37:0])) <<< 13) + ITERM_W'(iacc_q);
			S_IADD: total_q <= total_q + TOTAL_W'(iclamp);
			S_DADD: total_q <= total_q + prod_term;
			S_CLAMP: total_q <= total_clamp;
			default: ;
		endcase
		if (out_load) begin
			drive_q       <= drive_n;
			integrating_q <= !off_q && integ_active_q;
		end
	end

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state is not one-hot");

	a_inactive_sum_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PROP && !integ_active_q &&
		 (mode_q == MODE_SPEED || mode_q == MODE_ANGLE)) |-> integ_sum_q == '0)
		else $error("integrator not cleared while integration is off");

	a_total_within_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && !off_q) |-> (total_q <= dlim && total_q >= -dlim))
		else $error("drive total outside its limit");

	a_off_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_take && mode_q == MODE_OFF) |=>
		(integ_sum_q == $past(integ_sum_q) && prev_error_q == $past(prev_error_q) &&
		 integ_active_q == $past(integ_active_q)))
		else $error("off mode changed the loop state");

endmodule
